// ===== rtl/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg: shared types and constants of the mecanum wheel mixer
// beat payload structs, register reset value and default widths
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

	localparam int CMD_W            = 16;
	localparam int DUTY_W           = 8;
	localparam int MAX_W            = 8;
	localparam int NUM_WHEELS       = 4;

	// wheel order inside the datapath
	localparam int WHL_FR           = 0;
	localparam int WHL_FL           = 1;
	localparam int WHL_RR           = 2;
	localparam int WHL_RL           = 3;

	localparam int DEF_CMD_FRAC_BITS = 14;
	localparam int DEF_DUTY_BITS     = 8;

	localparam logic [MAX_W-1:0] MAX_SPEED_RST = 8'd255;

	typedef struct packed {
		logic signed [CMD_W-1:0] drive_cmd;
		logic signed [CMD_W-1:0] turn_cmd;
		logic signed [CMD_W-1:0] strafe_cmd;
	} cmd_t;

	typedef struct packed {
		logic [DUTY_W-1:0] front_right_duty;
		logic              front_right_dir;
		logic [DUTY_W-1:0] front_left_duty;
		logic              front_left_dir;
		logic [DUTY_W-1:0] rear_right_duty;
		logic              rear_right_dir;
		logic [DUTY_W-1:0] rear_left_duty;
		logic              rear_left_dir;
		logic              was_scaled;
	} mix_t;

endpackage

`default_nettype wire

// ===== rtl/mwm_divider.sv =====
// ----------------------------------------------------------------------------
// mwm_divider: four-lane pipelined restoring divider
// one quotient bit per stage, one stage per quotient bit, shared divisor
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_divider #(
	parameter int MAG_W = mwm_pkg::DEF_CMD_FRAC_BITS + 2,
	parameter int DB    = mwm_pkg::DEF_DUTY_BITS
) (
	input  wire logic                                       clk,
	input  wire logic [DB-1:0]                              adv,
	input  wire logic [mwm_pkg::NUM_WHEELS-1:0][MAG_W-1:0] rem_in,
	input  wire logic [mwm_pkg::NUM_WHEELS-1:0][DB-1:0]    low_in,
	input  wire logic [MAG_W-1:0]                           dvs_in,
	output logic      [mwm_pkg::NUM_WHEELS-1:0][DB-1:0]    quo
);

	localparam int NW = mwm_pkg::NUM_WHEELS;

	logic [NW-1:0][MAG_W-1:0] rem_s [DB];
	logic [NW-1:0][DB-1:0]    low_s [DB];
	logic [NW-1:0][DB-1:0]    quo_s [DB];
	logic [MAG_W-1:0]         dvs_s [DB];

	for (genvar j = 0; j < DB; j++) begin : g_stg
		logic [NW-1:0][MAG_W-1:0] r_src;
		logic [NW-1:0][DB-1:0]    l_src;
		logic [NW-1:0][DB-1:0]    q_src;
		logic [MAG_W-1:0]         d_src;
		logic [NW-1:0][MAG_W-1:0] r_nxt;
		logic [NW-1:0][DB-1:0]    q_nxt;

		if (j == 0) begin : g_first
			assign r_src = rem_in;
			assign l_src = low_in;
			assign q_src = '0;
			assign d_src = dvs_in;
		end else begin : g_next
			assign r_src = rem_s[j-1];
			assign l_src = low_s[j-1];
			assign q_src = quo_s[j-1];
			assign d_src = dvs_s[j-1];
		end

		// trial subtract of the divisor from the shifted partial remainder
		always_comb begin
			logic [MAG_W:0] trial;
			for (int w = 0; w < NW; w++) begin
				trial = {r_src[w], l_src[w][DB-1]};
				if (trial >= {1'b0, d_src}) begin
					r_nxt[w] = MAG_W'(trial - {1'b0, d_src});
					q_nxt[w] = {q_src[w][DB-2:0], 1'b1};
				end else begin
					r_nxt[w] = trial[MAG_W-1:0];
					q_nxt[w] = {q_src[w][DB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[j]) begin
				rem_s[j] <= r_nxt;
				quo_s[j] <= q_nxt;
				dvs_s[j] <= d_src;
				for (int w = 0; w < NW; w++) begin
					low_s[j][w] <= {l_src[w][DB-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[DB-1];

endmodule

`default_nettype wire

// ===== rtl/mecanum_wheel_mixer.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer: drive/turn/strafe to four wheel duties
// saturates the commands, mixes them, scales by max speed and renormalizes
// ----------------------------------------------------------------------------
//
//  channel  | signals                      | dir | one beat
//  ---------+------------------------------+-----+---------------------------
//  command  | cmd_valid cmd_ready cmd      | in  | drive, turn, strafe Q2.14
//  mix      | mix_valid mix_ready mix      | out | four duties, dirs, scaled
//  config   | cfg_we cfg_wdata             | in  | max speed, no wait
//
//  a command beat can enter every clock while the pipe is not stalled;
//  the pipe depth is set by the divider, which produces one quotient bit
//  per stage
//  stages: s1 clamp/mix/abs, s2 largest and products, DUTY_BITS divider
//  stages, s3 output register
//  each full stage holds while the one after it is full and stalled, so a stalled
//  mix beat holds the run of full stages behind it up to the first empty one; nothing is dropped
//  reset empties the pipe and sets max speed to 255
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_mixer #(
	parameter int CMD_FRAC_BITS = mwm_pkg::DEF_CMD_FRAC_BITS,
	parameter int DUTY_BITS     = mwm_pkg::DEF_DUTY_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output logic                            cmd_ready,
	input  wire mwm_pkg::cmd_t              cmd,
	output logic                            mix_valid,
	input  wire logic                       mix_ready,
	output mwm_pkg::mix_t                   mix,
	input  wire logic                       cfg_we,
	input  wire logic [mwm_pkg::MAX_W-1:0]  cfg_wdata
);

	localparam int F      = CMD_FRAC_BITS;
	localparam int DB     = DUTY_BITS;
	localparam int NW     = mwm_pkg::NUM_WHEELS;
	localparam int DW     = mwm_pkg::DUTY_W;
	// a clamped command needs F+2 signed bits, a sum of three F+3 (held in F+4)
	localparam int CLP_W  = F + 2;
	localparam int SUM_W  = F + 4;
	// |sum| <= 3 * one < 2^(F+2)
	localparam int MAG_W  = F + 2;
	localparam int P_W    = MAG_W + DB;
	localparam int CMP_W  = (F + 2 > mwm_pkg::CMD_W + 1) ? F + 2 : mwm_pkg::CMD_W + 1;
	localparam int NSTG   = DB + 3;

	localparam logic signed [CMP_W-1:0] ONE_C = CMP_W'(1) << F;
	localparam logic [MAG_W-1:0]        ONE_U = MAG_W'(1) << F;

	// saturate a raw command to plus or minus one
	function automatic logic signed [CLP_W-1:0] clamp_cmd(
		input logic signed [mwm_pkg::CMD_W-1:0] raw
	);
		logic signed [CMP_W-1:0] x;
		logic signed [CMP_W-1:0] r;
		x = CMP_W'(raw);
		if (x > ONE_C) begin
			r = ONE_C;
		end else if (x < -ONE_C) begin
			r = -ONE_C;
		end else begin
			r = x;
		end
		return r[CLP_W-1:0];
	endfunction

	// ---------------------------------------------------------------- config
	logic [mwm_pkg::MAX_W-1:0] max_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= mwm_pkg::MAX_SPEED_RST;
		end else if (cfg_we) begin
			max_speed_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------- valid / enables
	// stage k loads when it is empty or its content moves on
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	assign en[NSTG-1] = !vld_q[NSTG-1] || mix_ready;
	for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? cmd_valid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	assign cmd_ready = en[0];
	assign mix_valid = vld_q[NSTG-1];

	// ------------------------------------------------- s1: clamp, mix, abs
	logic signed [SUM_W-1:0] d_c, t_c, s_c;
	logic signed [SUM_W-1:0] sum_c [NW];

	always_comb begin
		d_c = SUM_W'(clamp_cmd(cmd.drive_cmd));
		t_c = SUM_W'(clamp_cmd(cmd.turn_cmd));
		s_c = SUM_W'(clamp_cmd(cmd.strafe_cmd));
		sum_c[mwm_pkg::WHL_FR] = d_c + t_c + s_c;
		sum_c[mwm_pkg::WHL_FL] = d_c - t_c - s_c;
		sum_c[mwm_pkg::WHL_RR] = d_c + t_c - s_c;
		sum_c[mwm_pkg::WHL_RL] = d_c - t_c + s_c;
	end

	logic [NW-1:0][MAG_W-1:0]  mag_s1;
	logic [NW-1:0]             pos_s1;
	logic [mwm_pkg::MAX_W-1:0] max_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int w = 0; w < NW; w++) begin
				mag_s1[w] <= (sum_c[w] < 0) ? MAG_W'(-sum_c[w]) : MAG_W'(sum_c[w]);
				pos_s1[w] <= sum_c[w] > 0;
			end
			max_s1 <= max_speed_q;
		end
	end

	// ---------------------------------------- s2: largest, products, flags
	logic [MAG_W-1:0] lg_a, lg_b, lg_c;
	logic [DB-1:0]    max_ext;
	logic             max_nz;

	always_comb begin
		lg_a    = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		lg_b    = (mag_s1[2] > mag_s1[3]) ? mag_s1[2] : mag_s1[3];
		lg_c    = (lg_a > lg_b) ? lg_a : lg_b;
		max_ext = DB'(max_s1);
		max_nz  = max_s1 != '0;
	end

	// what rides alongside the divider
	typedef struct packed {
		logic                   scale;
		logic [NW-1:0]          pos;
		logic [NW-1:0][DW-1:0]  dz;
	} side_t;

	logic [NW-1:0][P_W-1:0] prod_s2;
	logic [MAG_W-1:0]       lg_s2;
	side_t                  side_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int w = 0; w < NW; w++) begin
				prod_s2[w]       <= P_W'(mag_s1[w]) * P_W'(max_ext);
				side_s2.dz[w]    <= DW'((P_W'(mag_s1[w]) * P_W'(max_ext)) >> F);
				side_s2.pos[w]   <= pos_s1[w] && max_nz;
			end
			side_s2.scale <= max_nz && (lg_c > ONE_U);
			lg_s2         <= lg_c;
		end
	end

	// ------------------------------------------------------ divider stages
	logic [NW-1:0][MAG_W-1:0] rem_in;
	logic [NW-1:0][DB-1:0]    low_in;
	logic [NW-1:0][DB-1:0]    quo;

	always_comb begin
		for (int w = 0; w < NW; w++) begin
			rem_in[w] = prod_s2[w][P_W-1:DB];
			low_in[w] = prod_s2[w][DB-1:0];
		end
	end

	mwm_divider #(
		.MAG_W (MAG_W),
		.DB    (DB)
	) u_div (
		.clk    (clk),
		.adv    (en[DB+1:2]),
		.rem_in (rem_in),
		.low_in (low_in),
		.dvs_in (lg_s2),
		.quo    (quo)
	);

	side_t side_sd [DB];

	for (genvar j = 0; j < DB; j++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[j+2]) begin
				side_sd[j] <= (j == 0) ? side_s2 : side_sd[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// ------------------------------------------------ s3: output register
	side_t                 side_l;
	logic [NW-1:0][DW-1:0] duty_c;

	always_comb begin
		side_l = side_sd[DB-1];
		for (int w = 0; w < NW; w++) begin
			duty_c[w] = side_l.scale ? DW'(quo[w]) : side_l.dz[w];
		end
	end

	mwm_pkg::mix_t mix_s3;

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			mix_s3.front_right_duty <= duty_c[mwm_pkg::WHL_FR];
			mix_s3.front_right_dir  <= side_l.pos[mwm_pkg::WHL_FR];
			mix_s3.front_left_duty  <= duty_c[mwm_pkg::WHL_FL];
			// left side is mirrored
			mix_s3.front_left_dir   <= !side_l.pos[mwm_pkg::WHL_FL];
			mix_s3.rear_right_duty  <= duty_c[mwm_pkg::WHL_RR];
			mix_s3.rear_right_dir   <= side_l.pos[mwm_pkg::WHL_RR];
			mix_s3.rear_left_duty   <= duty_c[mwm_pkg::WHL_RL];
			mix_s3.rear_left_dir    <= !side_l.pos[mwm_pkg::WHL_RL];
			mix_s3.was_scaled       <= side_l.scale;
		end
	end

	assign mix = mix_s3;

endmodule

`default_nettype wire

// ===== rtl/mwm_checker.sv =====
// ----------------------------------------------------------------------------
// mwm_checker: port-level checks of the mecanum wheel mixer
// mirrors the max speed register and checks beat hold, zero max speed, duty bounds and scaling
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      mix_valid,
	input wire logic                      mix_ready,
	input wire mwm_pkg::mix_t             mix,
	input wire logic                      cfg_we,
	input wire logic [mwm_pkg::MAX_W-1:0] cfg_wdata
);

	logic [mwm_pkg::MAX_W-1:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= mwm_pkg::MAX_SPEED_RST;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && !mix_ready |=> mix_valid && $stable(mix))
		else $error("mix beat changed while stalled");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid |-> mix.front_right_duty <= max_q && mix.front_left_duty <= max_q
			&& mix.rear_right_duty <= max_q && mix.rear_left_duty <= max_q)
		else $error("duty above max speed");

	// the largest wheel lands exactly on max speed after rescale
	a_scaled: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && mix.was_scaled |-> mix.front_right_duty == max_q
			|| mix.front_left_duty == max_q || mix.rear_right_duty == max_q
			|| mix.rear_left_duty == max_q)
		else $error("rescale without a full duty wheel");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && max_q == '0 |-> !mix.was_scaled && !mix.front_right_dir
			&& !mix.rear_right_dir && mix.front_left_dir && mix.rear_left_dir)
		else $error("zero max speed gave a drive");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.mix_valid (mix_valid),
	.mix_ready (mix_ready),
	.mix       (mix),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata)
);

`default_nettype wire
